>>> src/ifgen_pkg.sv
// ifgen_pkg: shared constants and types for the IPv4 fragment header generator.
// No dependencies; imported by all ifgen modules, the top level and the testbench.
`timescale 1ns / 1ps

package ifgen_pkg;

  localparam int FRAG_PAYLOAD = 1480;
  localparam int HDR_BYTES    = 20;
  localparam int TTL_VALUE    = 64;

  localparam logic [15:0] FRAG_BYTES   = 16'(FRAG_PAYLOAD);
  localparam logic [15:0] VER_IHL_TOS  = 16'h4500;
  localparam logic [15:0] TTL_WORD     = 16'(TTL_VALUE << 8);
  localparam logic [10:0] HDR_LEN      = 11'(HDR_BYTES);

  // Width of the partial checksum: seven 16-bit words, then two more.
  localparam int BASE_W = 19;
  localparam int SUM_W  = 20;

  typedef struct packed {
    logic [15:0] slice_offset;
    logic [10:0] slice_length;
    logic [10:0] total_length;
    logic [15:0] identification;
    logic [13:0] flags_offset;
    logic [7:0]  proto_out;
    logic [31:0] dest_out;
    logic [15:0] header_checksum;
    logic        last_fragment;
  } hdr_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic base;
    logic emit;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic last;
  } dp_sts_t;

endpackage

>>> src/ifgen_if.sv
// ifgen_req_if / ifgen_hdr_if: valid/ready channels for requests and header words.
// Depends on nothing but the field widths of the work items.
`timescale 1ns / 1ps

interface ifgen_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] payload_length;
  logic [31:0] dest_ip;
  logic [7:0]  protocol;

  modport source (output valid, output payload_length, output dest_ip, output protocol,
                  input ready);
  modport sink   (input valid, input payload_length, input dest_ip, input protocol,
                  output ready);
endinterface

interface ifgen_hdr_if;
  logic        valid;
  logic        ready;
  logic [15:0] slice_offset;
  logic [10:0] slice_length;
  logic [10:0] total_length;
  logic [15:0] identification;
  logic [13:0] flags_offset;
  logic [7:0]  proto_out;
  logic [31:0] dest_out;
  logic [15:0] header_checksum;
  logic        last_fragment;

  modport source (output valid, output slice_offset, output slice_length,
                  output total_length, output identification, output flags_offset,
                  output proto_out, output dest_out, output header_checksum,
                  output last_fragment, input ready);
  modport sink   (input valid, input slice_offset, input slice_length,
                  input total_length, input identification, input flags_offset,
                  input proto_out, input dest_out, input header_checksum,
                  input last_fragment, output ready);
endinterface

>>> src/ifgen_ctrl.sv
// ifgen_ctrl: sequencer for one request at a time and the output valid flag.
// Depends on ifgen_pkg for the command and status structs.
`timescale 1ns / 1ps

module ifgen_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ifgen_pkg::dp_cmd_t cmd,
  input  ifgen_pkg::dp_sts_t sts
);
  import ifgen_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_BASE, ST_EMIT} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_BASE;
        end
      end
      ST_BASE: begin
        cmd.base  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // advance only when the output register is free or being drained
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          if (sts.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> src/ifgen_dp.sv
// ifgen_dp: request registers, fragment walker, checksum and output register.
// Depends on ifgen_pkg for constants, hdr_t and the command/status structs.
`timescale 1ns / 1ps

module ifgen_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata,
  input  logic [15:0]       req_length,
  input  logic [31:0]       req_dest,
  input  logic [7:0]        req_proto,
  input  ifgen_pkg::dp_cmd_t cmd,
  output ifgen_pkg::dp_sts_t sts,
  output ifgen_pkg::hdr_t    hdr
);
  import ifgen_pkg::*;

  logic [31:0]       local_ip_r;
  logic [15:0]       ctr_r;
  logic [15:0]       rem_r;
  logic [15:0]       off_r;
  logic [31:0]       dest_r;
  logic [7:0]        proto_r;
  logic [15:0]       ident_r;
  logic [BASE_W-1:0] base_r;
  hdr_t              hdr_r;

  logic              last;
  logic [10:0]       slen;
  logic [10:0]       tlen;
  logic [13:0]       fo;
  logic [SUM_W-1:0]  sum;
  logic [16:0]       fold1;
  logic [15:0]       fold2;
  logic [BASE_W-1:0] base_nxt;

  // Fixed words of the header: everything but total length and flags/offset.
  always_comb begin
    base_nxt = BASE_W'(VER_IHL_TOS) + BASE_W'(TTL_WORD | {8'h00, proto_r})
             + BASE_W'(ident_r)
             + BASE_W'(local_ip_r[31:16]) + BASE_W'(local_ip_r[15:0])
             + BASE_W'(dest_r[31:16]) + BASE_W'(dest_r[15:0]);
  end

  // Remaining bytes fit in one piece: this is the final fragment.
  assign last = (rem_r <= FRAG_BYTES);
  assign slen = last ? rem_r[10:0] : FRAG_BYTES[10:0];
  assign tlen = slen + HDR_LEN;
  assign fo   = {~last, off_r[15:3]};

  always_comb begin
    sum   = SUM_W'(base_r) + SUM_W'(tlen) + SUM_W'(fo);
    fold1 = 17'(sum[15:0]) + 17'(sum[SUM_W-1:16]);
    fold2 = fold1[15:0] + 16'(fold1[16]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_ip_r <= '0;
      ctr_r      <= '0;
    end else begin
      if (cfg_we) begin
        local_ip_r <= cfg_wdata;
      end
      if (cmd.capture) begin
        ctr_r <= ctr_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rem_r   <= req_length;
      off_r   <= '0;
      dest_r  <= req_dest;
      proto_r <= req_proto;
      ident_r <= ctr_r;
    end
    if (cmd.base) begin
      base_r <= base_nxt;
    end
    if (cmd.emit) begin
      rem_r                  <= rem_r - FRAG_BYTES;
      off_r                  <= off_r + FRAG_BYTES;
      hdr_r.slice_offset     <= off_r;
      hdr_r.slice_length     <= slen;
      hdr_r.total_length     <= tlen;
      hdr_r.identification   <= ident_r;
      hdr_r.flags_offset     <= fo;
      hdr_r.proto_out        <= proto_r;
      hdr_r.dest_out         <= dest_r;
      hdr_r.header_checksum  <= ~fold2;
      hdr_r.last_fragment    <= last;
    end
  end

  assign sts.last = last;
  assign hdr      = hdr_r;

endmodule

>>> src/ipv4_fragment_header_gen_top.sv
// ipv4_fragment_header_gen_top: splits a send request into IPv4 fragment headers.
// Throughput: one header word per cycle while out_hdr.ready does not stall, set by the
// single fragment walker in the datapath; a new request is taken only after the last word.
// Reset (rst_n, synchronous, active low) clears local_ip, the datagram counter and the controller.
// Depends on ifgen_pkg, ifgen_if, ifgen_ctrl and ifgen_dp.
`timescale 1ns / 1ps

module ipv4_fragment_header_gen_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  ifgen_req_if.sink   in_req,
  ifgen_hdr_if.source out_hdr
);
  import ifgen_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  hdr_t    hdr;

  ifgen_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_hdr.valid),
    .out_ready (out_hdr.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ifgen_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req_length (in_req.payload_length),
    .req_dest   (in_req.dest_ip),
    .req_proto  (in_req.protocol),
    .cmd        (cmd),
    .sts        (sts),
    .hdr        (hdr)
  );

  assign out_hdr.slice_offset    = hdr.slice_offset;
  assign out_hdr.slice_length    = hdr.slice_length;
  assign out_hdr.total_length    = hdr.total_length;
  assign out_hdr.identification  = hdr.identification;
  assign out_hdr.flags_offset    = hdr.flags_offset;
  assign out_hdr.proto_out       = hdr.proto_out;
  assign out_hdr.dest_out        = hdr.dest_out;
  assign out_hdr.header_checksum = hdr.header_checksum;
  assign out_hdr.last_fragment   = hdr.last_fragment;

endmodule

>>> tb/tb_ipv4_fragment_header_gen_top.sv
// Testbench for ipv4_fragment_header_gen_top: drives send requests, predicts every fragment
// header and checks each output word field by field. Depends on ifgen_pkg and ifgen_if.
`timescale 1ns / 1ps

module tb_ipv4_fragment_header_gen_top;
  import ifgen_pkg::*;

  localparam int PIECE_BYTES  = 1480;
  localparam int MAX_PIECES   = 45;
  localparam int MF_FLAG      = 'h2000;
  localparam int RESET_ROWS   = 2;
  localparam int DIR_N        = 22;
  localparam int PHASES       = 4;
  localparam int PHASE_ITEMS  = 25;
  localparam int LONG_HOLD    = 300;
  localparam int TAIL_CYCLES  = 64;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int REPORT_MAX   = 10;
  localparam int N_FIELDS     = 9;

  typedef struct packed {
    logic [15:0] len;
    logic [31:0] dst;
    logic [7:0]  proto;
    logic        typed;
    hdr_t        want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  ifgen_req_if req_if ();
  ifgen_hdr_if hdr_if ();

  ipv4_fragment_header_gen_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_req   (req_if),
    .out_hdr  (hdr_if)
  );

  // Predictor state: source address and next datagram id.
  logic [31:0] src_ip;
  logic [15:0] next_ident;
  hdr_t        pending_hdrs[$];

  int  n_err;
  int  n_hdr_seen;
  bit  quiet_tail;
  bit  long_hold_done;
  int  cycle_cnt;

  string field_names[N_FIELDS] = '{"slice_offset", "slice_length", "total_length",
                                   "identification", "flags_offset", "proto_out",
                                   "dest_out", "header_checksum", "last_fragment"};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [15:0] ip_header_checksum(logic [15:0] tlen, logic [15:0] ident,
                                                     logic [15:0] fo, logic [7:0] proto,
                                                     logic [31:0] src, logic [31:0] dst);
    logic [31:0] sum;
    sum = 32'h4500 + tlen + ident + fo + {16'd0, 8'd64, proto}
        + src[31:16] + src[15:0] + dst[31:16] + dst[15:0];
    sum = {16'd0, sum[15:0]} + {16'd0, sum[31:16]};
    sum = {16'd0, sum[15:0]} + {16'd0, sum[31:16]};
    return ~sum[15:0];
  endfunction

  // Append the headers of one request and advance the datagram id.
  function automatic void predict_fragments(logic [15:0] len, logic [31:0] dst,
                                            logic [7:0] proto);
    int   pieces;
    int   off;
    int   slen;
    int   fo;
    bit   last;
    hdr_t h;
    pieces = (int'(len) + PIECE_BYTES - 1) / PIECE_BYTES;
    if (pieces == 0) pieces = 1;
    for (int i = 0; i < pieces && i < MAX_PIECES; i++) begin
      off  = i * PIECE_BYTES;
      last = (i + 1 == pieces);
      slen = last ? int'(len) - off : PIECE_BYTES;
      fo   = ((off >> 3) & 'h1FFF) | (last ? 0 : MF_FLAG);
      h.slice_offset    = 16'(off);
      h.slice_length    = 11'(slen);
      h.total_length    = 11'(slen + 20);
      h.identification  = next_ident;
      h.flags_offset    = 14'(fo);
      h.proto_out       = proto;
      h.dest_out        = dst;
      h.header_checksum = ip_header_checksum(16'(slen + 20), next_ident, 16'(fo), proto,
                                             src_ip, dst);
      h.last_fragment   = last;
      pending_hdrs.push_back(h);
    end
    next_ident = next_ident + 16'd1;
  endfunction

  function automatic void split_fields(hdr_t h, output logic [31:0] f[N_FIELDS]);
    f[0] = 32'(h.slice_offset);
    f[1] = 32'(h.slice_length);
    f[2] = 32'(h.total_length);
    f[3] = 32'(h.identification);
    f[4] = 32'(h.flags_offset);
    f[5] = 32'(h.proto_out);
    f[6] = h.dest_out;
    f[7] = 32'(h.header_checksum);
    f[8] = 32'(h.last_fragment);
  endfunction

  function automatic stim_row_t row(logic [15:0] len, logic [31:0] dst, logic [7:0] proto);
    return {len, dst, proto, 1'b0, hdr_t'(0)};
  endfunction

  function automatic stim_row_t trow(logic [15:0] len, logic [31:0] dst, logic [7:0] proto,
                                     hdr_t want);
    return {len, dst, proto, 1'b1, want};
  endfunction

  task automatic send_req(stim_row_t r);
    @(negedge clk);
    req_if.valid          = 1'b1;
    req_if.payload_length = r.len;
    req_if.dest_ip        = r.dst;
    req_if.protocol       = r.proto;
    do @(posedge clk); while (!req_if.ready);
    predict_fragments(r.len, r.dst, r.proto);
    // Typed rows are single-fragment: replace the prediction with the hand value.
    if (r.typed) pending_hdrs[pending_hdrs.size() - 1] = r.want;
  endtask

  task automatic idle_req(int n);
    repeat (n) begin
      @(negedge clk);
      req_if.valid = 1'b0;
    end
  endtask

  task automatic maybe_idle_req();
    if (!quiet_tail && $urandom_range(0, 3) == 0) idle_req($urandom_range(1, 13));
  endtask

  task automatic drain();
    idle_req(1);
    while (pending_hdrs.size() != 0) @(posedge clk);
  endtask

  task automatic write_local_ip(logic [31:0] v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
    src_ip    = v;
  endtask

  task automatic random_request(output stim_row_t r);
    logic [15:0] len;
    case ($urandom_range(0, 9))
      0:       len = 16'd0;
      1:       len = 16'(PIECE_BYTES * $urandom_range(1, 44));
      2:       len = 16'(PIECE_BYTES * $urandom_range(1, 44) + $urandom_range(0, 2) - 1);
      3:       len = 16'($urandom_range(0, 65535));
      default: len = 16'($urandom_range(1, 3000));
    endcase
    r = row(len, $urandom, 8'($urandom_range(0, 255)));
  endtask

  // Output monitor: compare each accepted word with the oldest expectation.
  always @(posedge clk) begin
    logic [31:0] ef[N_FIELDS];
    logic [31:0] af[N_FIELDS];
    hdr_t        got;
    hdr_t        want;
    if (rst_n && hdr_if.valid && hdr_if.ready) begin
      n_hdr_seen++;
      got = {hdr_if.slice_offset, hdr_if.slice_length, hdr_if.total_length,
             hdr_if.identification, hdr_if.flags_offset, hdr_if.proto_out,
             hdr_if.dest_out, hdr_if.header_checksum, hdr_if.last_fragment};
      if (pending_hdrs.size() == 0) begin
        n_err++;
        if (n_err <= REPORT_MAX) $display("unexpected header word: %h", got);
      end else begin
        want = pending_hdrs.pop_front();
        split_fields(want, ef);
        split_fields(got, af);
        for (int k = 0; k < N_FIELDS; k++) begin
          if (af[k] !== ef[k]) begin
            n_err++;
            if (n_err <= REPORT_MAX)
              $display("mismatch %s (ident %h): expected %h, got %h",
                       field_names[k], want.identification, ef[k], af[k]);
          end
        end
      end
    end
  end

  // Output side: random stalls, and one long hold while requests keep coming.
  initial begin
    int stall;
    hdr_if.ready = 1'b0;
    long_hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = 0;
      if (!long_hold_done && n_hdr_seen >= 40) begin
        long_hold_done = 1'b1;
        stall = LONG_HOLD;
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 13);
      end
      if (stall > 0) begin
        hdr_if.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      hdr_if.ready = 1'b1;
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    stim_row_t dir_rows[DIR_N];
    stim_row_t r;
    logic [31:0] phase_ip;
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    req_if.valid          = 1'b0;
    req_if.payload_length = '0;
    req_if.dest_ip        = '0;
    req_if.protocol       = '0;
    src_ip                = '0;
    next_ident            = '0;
    n_err                 = 0;
    n_hdr_seen            = 0;
    quiet_tail            = 1'b0;

    dir_rows = '{
      // Reset values: source 0, id 0 then 1; empty payloads.
      trow(16'd0, 32'h0000_0000, 8'h00,
           {16'd0, 11'd0, 11'd20, 16'd0, 14'd0, 8'h00, 32'h0000_0000, 16'h7AEB, 1'b1}),
      trow(16'd0, 32'hFFFF_FFFF, 8'hFF,
           {16'd0, 11'd0, 11'd20, 16'd1, 14'd0, 8'hFF, 32'hFFFF_FFFF, 16'h79EB, 1'b1}),
      row(16'd1,     32'h0000_0001, 8'd1),
      row(16'd7,     32'h8000_0000, 8'd6),
      row(16'd8,     32'h7FFF_FFFF, 8'd17),
      row(16'd1479,  32'hAAAA_AAAA, 8'h80),
      row(16'd1480,  32'h5555_5555, 8'h7F),
      row(16'd1481,  32'hC0A8_0001, 8'd6),
      row(16'd2960,  32'h0A00_0001, 8'd17),
      row(16'd2961,  32'hFFFF_FFFF, 8'hFF),
      row(16'd65120, 32'h0102_0304, 8'd1),
      row(16'd65515, 32'hFFFF_FFFF, 8'hFF),
      row(16'd65535, 32'h0000_0000, 8'h00),
      row(16'd32768, 32'hAAAA_AAAA, 8'h55),
      row(16'h5555,  32'h5555_5555, 8'hAA),
      row(16'hAAAA,  32'hDEAD_BEEF, 8'd47),
      row(16'd0,     32'h1234_5678, 8'd50),
      row(16'd4440,  32'h8000_0001, 8'd132),
      row(16'd1488,  32'h0000_FFFF, 8'd2),
      row(16'd3000,  32'hFFFF_0000, 8'd89),
      row(16'd20,    32'h7F00_0001, 8'd6),
      row(16'd1500,  32'hE000_0001, 8'd17)
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      if (i == RESET_ROWS) begin
        drain();
        write_local_ip(32'hFFFF_FFFF);
      end
      maybe_idle_req();
      send_req(dir_rows[i]);
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0:       phase_ip = 32'h0000_0000;
        default: phase_ip = $urandom;
      endcase
      write_local_ip(phase_ip);
      // Run the last phase flat out on both sides.
      quiet_tail = (p == PHASES - 1);
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        random_request(r);
        maybe_idle_req();
        send_req(r);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_err == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
